// ----- design/rpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared types and constants for the per-peer token bucket limiter.
// ----------------------------------------------------------------------------
package rpl_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int FRAC_BITS         = 24;
    localparam int LEVEL_W           = 40;
    localparam int TIME_W            = 32;
    localparam int BYTES_W           = 33;
    localparam int PROD_W            = 52;
    localparam int THR_W             = 36;
    localparam int DIVIDEND_W        = 60;
    localparam int DIVISOR_W         = 20;

    localparam logic [19:0] PPS_RESET   = 20'd1000;
    localparam logic [31:0] BLIM_RESET  = 32'd0;
    localparam logic [15:0] BURST_RESET = 16'd16;
    localparam logic [19:0] TPS_RESET   = 20'd1000;

    typedef enum logic [1:0] {
        ACT_CHECK  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ALLOWED  = 3'd0,
        ST_NO_TOKEN = 3'd1,
        ST_BYTE_LIM = 3'd2,
        ST_FULL     = 3'd3,
        ST_DONE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_PPS   = 2'd0,
        REG_BLIM  = 2'd1,
        REG_BURST = 2'd2,
        REG_TPS   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CAM_NOP    = 2'd0,
        CAM_INSERT = 2'd1,
        CAM_REMOVE = 2'd2,
        CAM_CLEAR  = 2'd3
    } cam_op_t;

    typedef struct packed {
        logic hit;
        logic has_free;
    } look_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_refill;
        logic [BYTES_W-1:0] bytes;
        logic [TIME_W-1:0]  window_start;
    } entry_t;

endpackage

// ----- design/rpl_cam.sv -----
// ----------------------------------------------------------------------------
// rpl_cam
// Peer key table with valid bits, parallel match and lowest free slot search.
// ----------------------------------------------------------------------------
module rpl_cam
    import rpl_pkg::*;
#(
    parameter int ENTRIES = DEF_TABLE_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      key,
    input  cam_op_t          op,
    input  logic [IDX_W-1:0] wr_idx,
    output look_t            look,
    output logic [IDX_W-1:0] hit_idx,
    output logic [IDX_W-1:0] free_idx
);

    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        key_reg [ENTRIES];
    logic [ENTRIES-1:0] match;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
        end
    end

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        look.hit      = |match;
        look.has_free = ~&valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            unique case (op)
                CAM_NOP:    valid_reg <= valid_reg;
                CAM_INSERT: valid_reg[wr_idx] <= 1'b1;
                CAM_REMOVE: valid_reg <= valid_reg & ~match;
                CAM_CLEAR:  valid_reg <= '0;
                default:    valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == CAM_INSERT)
        begin
            key_reg[wr_idx] <= key;
        end
    end

endmodule

// ----- design/rpl_mem.sv -----
// ----------------------------------------------------------------------------
// rpl_mem
// Bucket state memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpl_mem
    import rpl_pkg::*;
#(
    parameter int ENTRIES = DEF_TABLE_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rpl_div.sv -----
// ----------------------------------------------------------------------------
// rpl_div
// Restoring divider, one quotient bit per cycle, for the refill increment.
// ----------------------------------------------------------------------------
module rpl_div
    import rpl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [LEVEL_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic                  qbit;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign qbit     = (shifted >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg[LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], qbit};
            rem_reg <= qbit ? DIVISOR_W'(shifted - {1'b0, div_reg}) : shifted[DIVISOR_W-1:0];
        end
    end

endmodule

// ----- design/per_peer_token_bucket_limiter.sv -----
// ----------------------------------------------------------------------------
// per_peer_token_bucket_limiter
// Table of per-peer packet token buckets with one-second byte windows.
//
//   port group                      direction  handshake
//   start, action, peer_id, ...     in         taken when start && !busy
//   done, allowed, status           out        done high for one cycle
//   cfg_we, cfg_index, cfg_data     in         written when cfg_we is high
//
// Tick, remove and clear requests finish in S_LOOK, as does a check that finds
// a full table. Other checks pass S_LOOK, S_READ (known peers only), S_MUL and
// S_CMP; unless the bucket refills to full, they wait in S_DIV for the 60-step
// refill divider, and then finish through S_REFILL and S_TAKE.
// Reset clears all entries at once; no clearing pass is needed.
// Results cannot be stalled; a new request may be taken in the cycle its
// predecessor's result is shown.
// ----------------------------------------------------------------------------
module per_peer_token_bucket_limiter
    import rpl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] peer_id,
    input  logic [15:0] packet_bytes,
    output logic        done,
    output logic        allowed,
    output logic [2:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_MUL,
        S_CMP,
        S_DIV,
        S_REFILL,
        S_TAKE
    } state_t;

    state_t state_reg;

    logic [19:0] pps_reg;
    logic [31:0] blim_reg;
    logic [15:0] burst_reg;
    logic [19:0] tps_reg;
    logic [31:0] now_reg;

    action_t          action_reg;
    logic [31:0]      key_reg;
    logic [15:0]      pkt_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           entry_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [THR_W-1:0] thr_reg;
    logic             full_hit_reg;

    look_t            look;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    cam_op_t          cam_op;
    entry_t           rdata;
    entry_t           wdata;
    logic             div_start;
    logic             div_done;
    logic [LEVEL_W-1:0] quotient;

    logic [DIVISOR_W-1:0] tps_nz;
    logic [LEVEL_W-1:0]   full_level;
    logic [LEVEL_W:0]     level_sum;
    logic [LEVEL_W-1:0]   level_next;
    logic [TIME_W-1:0]    window_age;
    logic [TIME_W-1:0]    elapsed;
    logic [BYTES_W-1:0]   bytes_sum;
    logic                 full_hit;
    status_t              take_status;

    assign busy       = (state_reg != S_IDLE);
    assign tps_nz     = (tps_reg == '0) ? DIVISOR_W'(1) : tps_reg;
    assign full_level = {8'd0, burst_reg, 16'd0} << (FRAC_BITS - 16);
    assign level_sum  = {1'b0, entry_reg.level} + {1'b0, quotient};
    assign window_age = now_reg - entry_reg.window_start;
    assign elapsed    = now_reg - entry_reg.last_refill;
    assign bytes_sum  = entry_reg.bytes + BYTES_W'(pkt_reg);
    assign full_hit   = (prod_reg >= PROD_W'(thr_reg));
    assign div_start  = (state_reg == S_CMP) && !full_hit;

    always_comb
    begin
        if (full_hit_reg || (level_sum > {1'b0, full_level}))
        begin
            level_next = full_level;
        end
        else
        begin
            level_next = level_sum[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        wdata       = entry_reg;
        take_status = ST_ALLOWED;
        if (entry_reg.level < ONE_TOKEN)
        begin
            take_status = ST_NO_TOKEN;
        end
        else
        begin
            wdata.level = entry_reg.level - ONE_TOKEN;
            if (blim_reg != '0)
            begin
                if (bytes_sum > {1'b0, blim_reg})
                begin
                    take_status = ST_BYTE_LIM;
                end
                else
                begin
                    wdata.bytes = bytes_sum;
                end
            end
        end
    end

    always_comb
    begin
        cam_op = CAM_NOP;
        if (state_reg == S_LOOK)
        begin
            unique case (action_reg)
                ACT_CHECK:  cam_op = (!look.hit && look.has_free) ? CAM_INSERT : CAM_NOP;
                ACT_TICK:   cam_op = CAM_NOP;
                ACT_REMOVE: cam_op = CAM_REMOVE;
                ACT_CLEAR:  cam_op = CAM_CLEAR;
                default:    cam_op = CAM_NOP;
            endcase
        end
    end

    rpl_cam #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_reg),
        .op       (cam_op),
        .wr_idx   (free_idx),
        .look     (look),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    rpl_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (state_reg == S_TAKE),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (hit_idx),
        .rdata (rdata)
    );

    rpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_reg[THR_W-1:0], FRAC_BITS'(0)}),
        .divisor  (tps_nz),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg   <= PPS_RESET;
            blim_reg  <= BLIM_RESET;
            burst_reg <= BURST_RESET;
            tps_reg   <= TPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PPS:   pps_reg   <= cfg_data[19:0];
                REG_BLIM:  blim_reg  <= cfg_data;
                REG_BURST: burst_reg <= cfg_data[15:0];
                REG_TPS:   tps_reg   <= cfg_data[19:0];
                default:   pps_reg   <= pps_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            done      <= 1'b0;
            allowed   <= 1'b0;
            status    <= ST_DONE;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (action_reg == ACT_CHECK)
                    begin
                        if (look.hit)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (look.has_free)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            done      <= 1'b1;
                            allowed   <= 1'b0;
                            status    <= ST_FULL;
                        end
                    end
                    else
                    begin
                        if (action_reg == ACT_TICK)
                        begin
                            now_reg <= now_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                        done      <= 1'b1;
                        allowed   <= 1'b0;
                        status    <= ST_DONE;
                    end
                end
                S_READ:   state_reg <= S_MUL;
                S_MUL:    state_reg <= S_CMP;
                S_CMP:    state_reg <= full_hit ? S_REFILL : S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_REFILL;
                    end
                end
                S_REFILL: state_reg <= S_TAKE;
                S_TAKE:
                begin
                    state_reg <= S_IDLE;
                    done      <= 1'b1;
                    allowed   <= (take_status == ST_ALLOWED);
                    status    <= take_status;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            action_reg <= action_t'(action);
            key_reg    <= peer_id;
            pkt_reg    <= packet_bytes;
        end
        if (state_reg == S_LOOK)
        begin
            idx_reg                <= look.hit ? hit_idx : free_idx;
            entry_reg.level        <= full_level;
            entry_reg.last_refill  <= now_reg;
            entry_reg.bytes        <= '0;
            entry_reg.window_start <= now_reg;
        end
        if (state_reg == S_READ)
        begin
            entry_reg <= rdata;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(elapsed) * PROD_W'(pps_reg);
            thr_reg  <= THR_W'(burst_reg) * THR_W'(tps_nz);
        end
        if (state_reg == S_CMP)
        begin
            full_hit_reg <= full_hit;
        end
        if (state_reg == S_REFILL)
        begin
            entry_reg.level       <= level_next;
            entry_reg.last_refill <= now_reg;
            if (window_age >= TIME_W'(tps_nz))
            begin
                entry_reg.bytes        <= '0;
                entry_reg.window_start <= now_reg;
            end
        end
    end

endmodule
